// ===== design/scc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// System control coprocessor package
// Shared constants, access word type, address decode and ID tables.
// ----------------------------------------------------------------------------
package scc_pkg;

    // Access kinds
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Primary register numbers
    localparam logic [3:0] CRN_ID    = 4'd0;
    localparam logic [3:0] CRN_CTRL  = 4'd1;
    localparam logic [3:0] CRN_TTB   = 4'd2;
    localparam logic [3:0] CRN_DAC   = 4'd3;
    localparam logic [3:0] CRN_L2    = 4'd9;
    localparam logic [3:0] CRN_REMAP = 4'd15;

    // Secondary register numbers
    localparam logic [3:0] CRM_ZERO  = 4'd0;
    localparam logic [3:0] CRM_FEAT  = 4'd1;
    localparam logic [3:0] CRM_REMAP = 4'd2;

    // First opcode values
    localparam logic [2:0] OP1_STD = 3'd0;
    localparam logic [2:0] OP1_L2  = 3'd1;

    // Second opcode values
    localparam logic [2:0] OP2_0 = 3'd0;
    localparam logic [2:0] OP2_1 = 3'd1;
    localparam logic [2:0] OP2_2 = 3'd2;
    localparam logic [2:0] OP2_4 = 3'd4;

    // Write masks, forced-one and preserved bits
    localparam logic [31:0] CTRL1_WMASK = 32'h33e7_0b0f;
    localparam logic [31:0] CTRL1_ONES  = 32'h0000_0078;
    localparam logic [31:0] CTRL2_WMASK = 32'h7200_3c07;
    localparam logic [31:0] CTRL2_ONES  = 32'h00c5_0078;
    localparam logic [31:0] CTRL2_KEEP  = 32'h0800_0000;
    localparam logic [31:0] AUX1_WMASK  = 32'hf000_007f;
    localparam logic [31:0] AUX2_WMASK  = 32'h001f_ffff;
    localparam logic [31:0] AUX2_KEEP   = 32'hc000_0000;
    localparam logic [31:0] ACC_WMASK   = 32'h0fff_ffff;
    localparam logic [31:0] L2_WMASK    = 32'h3be1_01cf;

    // Reset values
    localparam logic [31:0] CTRL1_RST = 32'h0005_0078;
    localparam logic [31:0] CTRL2_RST = 32'h08c5_0078;
    localparam logic [31:0] AUX1_RST  = 32'h0000_0007;
    localparam logic [31:0] AUX2_RST  = 32'h0000_0002;
    localparam logic [31:0] L2_RST    = 32'h0000_0042;

    typedef enum logic [3:0] {
        SEL_NONE,
        SEL_ID,
        SEL_FEAT,
        SEL_CTRL,
        SEL_AUX,
        SEL_ACC,
        SEL_TTB0,
        SEL_TTB1,
        SEL_TTBC,
        SEL_DAC,
        SEL_L2AUX,
        SEL_REMAP
    } t_reg_sel;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  op1;
        logic [2:0]  op2;
        logic [3:0]  crn;
        logic [3:0]  crm;
        logic [31:0] wdata;
    } t_access;

    // Map an address onto the register it names
    function automatic t_reg_sel decode_sel(input logic [2:0] op1, input logic [2:0] op2,
                                            input logic [3:0] crn, input logic [3:0] crm,
                                            input logic second);
        t_reg_sel sel;
        sel = SEL_NONE;
        if (crn == CRN_ID && op1 == OP1_STD && crm == CRM_ZERO && !op2[2]) begin
            sel = SEL_ID;
        end else if (crn == CRN_ID && op1 == OP1_STD && crm == CRM_FEAT) begin
            sel = SEL_FEAT;
        end else if (crn == CRN_CTRL && op1 == OP1_STD && crm == CRM_ZERO) begin
            if (op2 == OP2_0)      sel = SEL_CTRL;
            else if (op2 == OP2_1) sel = SEL_AUX;
            else if (op2 == OP2_2) sel = SEL_ACC;
        end else if (crn == CRN_TTB && op1 == OP1_STD && crm == CRM_ZERO) begin
            if (op2 == OP2_0)      sel = SEL_TTB0;
            else if (op2 == OP2_1) sel = SEL_TTB1;
            else if (op2 == OP2_2) sel = SEL_TTBC;
        end else if (crn == CRN_DAC && op1 == OP1_STD && crm == CRM_ZERO && op2 == OP2_0) begin
            sel = SEL_DAC;
        end else if (crn == CRN_L2 && op1 == OP1_L2 && crm == CRM_ZERO && op2 == OP2_2) begin
            sel = SEL_L2AUX;
        end else if (crn == CRN_REMAP && op1 == OP1_STD && crm == CRM_REMAP && op2 == OP2_4
                     && !second) begin
            sel = SEL_REMAP;
        end
        return sel;
    endfunction

    // Identification words
    function automatic logic [31:0] id_word(input logic [1:0] idx);
        logic [31:0] w;
        case (idx)
            2'd0:    w = 32'h410f_8767;
            2'd1:    w = 32'h1015_2152;
            2'd2:    w = 32'h0002_0002;
            default: w = 32'h0000_0800;
        endcase
        return w;
    endfunction

    // Feature words
    function automatic logic [31:0] feat_word(input logic [2:0] idx);
        logic [31:0] w;
        case (idx)
            3'd0:    w = 32'h0000_0111;
            3'd1:    w = 32'h0000_0011;
            3'd2:    w = 32'h0000_0033;
            3'd4:    w = 32'h0113_0003;
            3'd5:    w = 32'h1003_0302;
            3'd6:    w = 32'h0122_2100;
            default: w = 32'h0000_0000;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== design/system_control_coprocessor_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// System control coprocessor registers
// Usage: each input word is one coprocessor access (read or write) with its
// opcode and register numbers. A read returns one output word holding the
// register value, zero when unmapped; a write returns nothing and updates
// the addressed register. i_cfg_we/i_cfg_wdata select the core variant and
// should only change while the block is idle.
// Pipeline: a read passes the input register, which loads at acceptance,
// then the result register, which loads once the read leaves the input
// register; a waiting result word can hold the read there.
// Throughput: one word per cycle while no read waits on a held result;
// the single decode, mask and read mux between the registers sets it.
// Reset: all registers return to their reset values, core variant 0, both
// pipeline slots empty.
// Stall: while the result word waits, a read in the input register holds,
// and input ready drops once that register is full; writes keep flowing.
// ----------------------------------------------------------------------------
module system_control_coprocessor_regs
    import scc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_req_type,
    input  wire logic [2:0]  i_op1,
    input  wire logic [2:0]  i_op2,
    input  wire logic [3:0]  i_primary_reg,
    input  wire logic [3:0]  i_secondary_reg,
    input  wire logic [31:0] i_write_value,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_read_value
);

    logic        r_core_kind;
    logic        r_s1_valid;
    t_access     r_s1;
    logic        r_out_valid;
    logic [31:0] r_read_value;
    logic [31:0] n_read_value;
    logic        s1_is_read;
    logic        s1_go;
    logic        wr_en;

    // Variant select register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_kind <= 1'b0;
        end else if (i_cfg_we) begin
            r_core_kind <= i_cfg_wdata;
        end
    end

    // Advance the input register when a write commits or a read finds room
    assign s1_is_read = (r_s1.req_type == REQ_READ);
    assign s1_go      = r_s1_valid && (!s1_is_read || !r_out_valid || i_out_ready);
    assign wr_en      = r_s1_valid && (r_s1.req_type == REQ_WRITE);
    assign o_in_ready = !r_s1_valid || s1_go;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1 <= '{req_type: i_req_type, op1: i_op1, op2: i_op2,
                      crn: i_primary_reg, crm: i_secondary_reg, wdata: i_write_value};
        end
    end

    scc_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_core_kind (r_core_kind),
        .i_wr_en     (wr_en),
        .i_acc       (r_s1),
        .o_rdata     (n_read_value)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_is_read) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_is_read) begin
            r_read_value <= n_read_value;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;

    // A new result comes only from a read leaving the input register
    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || i_out_ready) && !(s1_go && s1_is_read) |=> !r_out_valid)
        else $error("result word appeared without a read");

    // A read blocked by a waiting result stays in the input register
    a_read_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && s1_is_read && r_out_valid && !i_out_ready |=> r_s1_valid)
        else $error("blocked read dropped from input register");

    // A stalled result word holds its value
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_read_value))
        else $error("stalled result word changed or dropped");

endmodule
`default_nettype wire

// ===== design/scc_regfile.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// System control coprocessor register file
// Holds the writable registers, applies the per-variant write rules and
// muxes the read word for the access at the input.
// ----------------------------------------------------------------------------
module scc_regfile
    import scc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_core_kind,
    input  wire logic        i_wr_en,
    input  wire t_access     i_acc,
    output logic [31:0]      o_rdata
);

    logic [31:0] r_ctrl_first, r_ctrl_second, r_aux_first, r_aux_second;
    logic [31:0] r_acc_ctl, r_ttb0, r_ttb1, r_ttbc, r_dac, r_l2aux, r_remap;
    t_reg_sel    sel;

    // Decode the target register
    assign sel = decode_sel(i_acc.op1, i_acc.op2, i_acc.crn, i_acc.crm, i_core_kind);

    // Update the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_first  <= CTRL1_RST;
            r_ctrl_second <= CTRL2_RST;
            r_aux_first   <= AUX1_RST;
            r_aux_second  <= AUX2_RST;
            r_acc_ctl     <= '0;
            r_ttb0        <= '0;
            r_ttb1        <= '0;
            r_ttbc        <= '0;
            r_dac         <= '0;
            r_l2aux       <= L2_RST;
            r_remap       <= '0;
        end else if (i_wr_en) begin
            case (sel)
                SEL_CTRL: begin
                    if (i_core_kind) begin
                        r_ctrl_second <= (i_acc.wdata & CTRL2_WMASK) | CTRL2_ONES
                                         | (r_ctrl_second & CTRL2_KEEP);
                    end else begin
                        r_ctrl_first <= (i_acc.wdata & CTRL1_WMASK) | CTRL1_ONES;
                    end
                end
                SEL_AUX: begin
                    if (i_core_kind) begin
                        r_aux_second <= (i_acc.wdata & AUX2_WMASK)
                                        | (r_aux_second & AUX2_KEEP);
                    end else begin
                        r_aux_first <= i_acc.wdata & AUX1_WMASK;
                    end
                end
                SEL_ACC:   r_acc_ctl <= i_acc.wdata & ACC_WMASK;
                SEL_TTB0:  r_ttb0    <= i_acc.wdata;
                SEL_TTB1:  r_ttb1    <= i_acc.wdata;
                SEL_TTBC:  r_ttbc    <= i_acc.wdata;
                SEL_DAC:   r_dac     <= i_acc.wdata;
                SEL_L2AUX: r_l2aux   <= i_acc.wdata & L2_WMASK;
                SEL_REMAP: r_remap   <= i_acc.wdata;
                default: begin
                end
            endcase
        end
    end

    // Select the read word
    always_comb begin
        case (sel)
            SEL_ID:    o_rdata = id_word(i_acc.op2[1:0]);
            SEL_FEAT:  o_rdata = feat_word(i_acc.op2);
            SEL_CTRL:  o_rdata = i_core_kind ? r_ctrl_second : r_ctrl_first;
            SEL_AUX:   o_rdata = i_core_kind ? r_aux_second : r_aux_first;
            SEL_ACC:   o_rdata = r_acc_ctl;
            SEL_TTB0:  o_rdata = r_ttb0;
            SEL_TTB1:  o_rdata = r_ttb1;
            SEL_TTBC:  o_rdata = r_ttbc;
            SEL_DAC:   o_rdata = r_dac;
            SEL_L2AUX: o_rdata = r_l2aux;
            SEL_REMAP: o_rdata = r_remap;
            default:   o_rdata = '0;
        endcase
    end

    // Forced and preserved bits never drop; access control stays in its mask
    a_ctrl1_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctrl_first & CTRL1_ONES) == CTRL1_ONES)
        else $error("control forced-one bits lost on first variant");

    a_ctrl2_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctrl_second & (CTRL2_KEEP | CTRL2_ONES)) == (CTRL2_KEEP | CTRL2_ONES))
        else $error("control preserved or forced bits lost on second variant");

    a_acc_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc_ctl & ~ACC_WMASK) == 32'h0)
        else $error("access control holds bits outside its write mask");

endmodule
`default_nettype wire

// ===== bench/tb_system_control_coprocessor_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// System control coprocessor register bench
// Drives read and write accesses into the register block under both core
// variants. A scoreboard tracks its own register state, works out every read
// word and checks each returned word in order. The traffic mixes decoded
// addresses with random ones, and both ends stall at random.
// ----------------------------------------------------------------------------
module tb_system_control_coprocessor_regs;
    import scc_pkg::*;

    localparam int RAND_PER_PHASE = 215;
    localparam int NUM_PHASES     = 6;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 4;

    localparam logic [31:0] ID_WORDS [4] = '{
        32'h410f_8767, 32'h1015_2152, 32'h0002_0002, 32'h0000_0800
    };
    localparam logic [31:0] FEAT_WORDS [8] = '{
        32'h0000_0111, 32'h0000_0011, 32'h0000_0033, 32'h0000_0000,
        32'h0113_0003, 32'h1003_0302, 32'h0122_2100, 32'h0000_0000
    };

    // Address groups that random traffic aims at
    typedef enum int {
        AK_ID, AK_FEAT, AK_CTRL_ANY, AK_CTRL, AK_AUX, AK_TTB,
        AK_DAC, AK_L2, AK_REMAP, AK_MAINT
    } addr_kind_e;

    // Register state tracker and read word checker
    class cp_reg_scoreboard;
        bit          second;
        logic [31:0] ctrl_a, ctrl_b, aux_a, aux_b, acc;
        logic [31:0] ttb0, ttb1, ttbc, dac, l2aux, remap;
        logic [31:0] read_words_due[$];
        int          mismatches;
        int          reads_checked;
        int          writes_noted;

        function new();
            second        = 1'b0;
            ctrl_a        = CTRL1_RST;
            ctrl_b        = CTRL2_RST;
            aux_a         = AUX1_RST;
            aux_b         = AUX2_RST;
            acc           = '0;
            ttb0          = '0;
            ttb1          = '0;
            ttbc          = '0;
            dac           = '0;
            l2aux         = L2_RST;
            remap         = '0;
            mismatches    = 0;
            reads_checked = 0;
            writes_noted  = 0;
        endfunction

        function void set_core(bit kind);
            second = kind;
        endfunction

        function int pending();
            return read_words_due.size();
        endfunction

        // Update state on a write, queue the word a read returns
        function void note_access(t_access a);
            logic [31:0] word;
            logic        std0;
            std0 = (a.op1 == OP1_STD) && (a.crm == CRM_ZERO);
            if (a.req_type == REQ_WRITE) begin
                writes_noted++;
                if (std0 && a.crn == CRN_CTRL) begin
                    case (a.op2)
                        OP2_0: begin
                            if (second)
                                ctrl_b = (a.wdata & CTRL2_WMASK) | CTRL2_ONES
                                         | (ctrl_b & CTRL2_KEEP);
                            else
                                ctrl_a = (a.wdata & CTRL1_WMASK) | CTRL1_ONES;
                        end
                        OP2_1: begin
                            if (second)
                                aux_b = (a.wdata & AUX2_WMASK) | (aux_b & AUX2_KEEP);
                            else
                                aux_a = a.wdata & AUX1_WMASK;
                        end
                        OP2_2: acc = a.wdata & ACC_WMASK;
                        default: ;
                    endcase
                end else if (std0 && a.crn == CRN_TTB) begin
                    case (a.op2)
                        OP2_0: ttb0 = a.wdata;
                        OP2_1: ttb1 = a.wdata;
                        OP2_2: ttbc = a.wdata;
                        default: ;
                    endcase
                end else if (std0 && a.crn == CRN_DAC && a.op2 == OP2_0) begin
                    dac = a.wdata;
                end else if (a.crn == CRN_L2 && a.op1 == OP1_L2 && a.crm == CRM_ZERO
                             && a.op2 == OP2_2) begin
                    l2aux = a.wdata & L2_WMASK;
                end else if (a.crn == CRN_REMAP && a.op1 == OP1_STD && a.crm == CRM_REMAP
                             && a.op2 == OP2_4 && !second) begin
                    remap = a.wdata;
                end
                return;
            end
            word = '0;
            if (a.crn == CRN_ID && std0 && a.op2 < 3'd4) begin
                word = ID_WORDS[a.op2[1:0]];
            end else if (a.crn == CRN_ID && a.op1 == OP1_STD && a.crm == CRM_FEAT) begin
                word = FEAT_WORDS[a.op2];
            end else if (std0 && a.crn == CRN_CTRL) begin
                case (a.op2)
                    OP2_0:   word = second ? ctrl_b : ctrl_a;
                    OP2_1:   word = second ? aux_b : aux_a;
                    OP2_2:   word = acc;
                    default: word = '0;
                endcase
            end else if (std0 && a.crn == CRN_TTB) begin
                case (a.op2)
                    OP2_0:   word = ttb0;
                    OP2_1:   word = ttb1;
                    OP2_2:   word = ttbc;
                    default: word = '0;
                endcase
            end else if (std0 && a.crn == CRN_DAC && a.op2 == OP2_0) begin
                word = dac;
            end else if (a.crn == CRN_L2 && a.op1 == OP1_L2 && a.crm == CRM_ZERO
                         && a.op2 == OP2_2) begin
                word = l2aux;
            end else if (a.crn == CRN_REMAP && a.op1 == OP1_STD && a.crm == CRM_REMAP
                         && a.op2 == OP2_4 && !second) begin
                word = remap;
            end
            read_words_due.push_back(word);
        endfunction

        // Compare a returned word with the oldest one due
        function void check_read(logic [31:0] got);
            logic [31:0] due;
            reads_checked++;
            if (read_words_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected read word: expected none, actual %08h", $time, got);
                return;
            end
            due = read_words_due.pop_front();
            if (got !== due) begin
                mismatches++;
                $display("%0t: read word mismatch: expected %08h, actual %08h",
                         $time, due, got);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_req_type;
    logic [2:0]  i_op1;
    logic [2:0]  i_op2;
    logic [3:0]  i_primary_reg;
    logic [3:0]  i_secondary_reg;
    logic [31:0] i_write_value;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_read_value;

    cp_reg_scoreboard sb;
    int send_idle;
    int recv_idle;
    bit hold_req;
    int hold_left;
    int core_switches;

    system_control_coprocessor_regs uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_op1           (i_op1),
        .i_op2           (i_op2),
        .i_primary_reg   (i_primary_reg),
        .i_secondary_reg (i_secondary_reg),
        .i_write_value   (i_write_value),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_read_value    (o_read_value)
    );

    always #2 i_clk = ~i_clk;

    // Build one access word
    function automatic t_access mk(logic rt, logic [2:0] op1, logic [2:0] op2,
                                   logic [3:0] crn, logic [3:0] crm, logic [31:0] v);
        t_access a;
        a.req_type = rt;
        a.op1      = op1;
        a.op2      = op2;
        a.crn      = crn;
        a.crm      = crm;
        a.wdata    = v;
        return a;
    endfunction

    // Pick a random access, mostly aimed at decoded addresses
    function automatic t_access random_access();
        t_access    a;
        addr_kind_e kind;
        int         sel;
        a.req_type = 1'($urandom_range(1));
        a.op1      = 3'($urandom_range(7));
        a.op2      = 3'($urandom_range(7));
        a.crn      = 4'($urandom_range(15));
        a.crm      = 4'($urandom_range(15));
        sel        = $urandom_range(7);
        a.wdata    = (sel == 0) ? 32'hffff_ffff : (sel == 1) ? 32'h0 : $urandom;
        if ($urandom_range(99) < 30) return a;
        kind  = addr_kind_e'($urandom_range(AK_MAINT));
        a.op1 = OP1_STD;
        a.crm = CRM_ZERO;
        case (kind)
            AK_ID:       a.crn = CRN_ID;
            AK_FEAT:     begin a.crn = CRN_ID; a.crm = CRM_FEAT; end
            AK_CTRL_ANY: begin a.crn = CRN_CTRL; a.op2 = 3'($urandom_range(3)); end
            AK_CTRL:     begin a.crn = CRN_CTRL; a.op2 = OP2_0; end
            AK_AUX:      begin a.crn = CRN_CTRL; a.op2 = OP2_1; end
            AK_TTB:      begin a.crn = CRN_TTB; a.op2 = 3'($urandom_range(3)); end
            AK_DAC:      begin a.crn = CRN_DAC; a.op2 = OP2_0; end
            AK_L2:       begin a.crn = CRN_L2; a.op1 = OP1_L2; a.op2 = OP2_2; end
            AK_REMAP:    begin a.crn = CRN_REMAP; a.crm = CRM_REMAP; a.op2 = OP2_4; end
            default: begin
                a.crn = ($urandom_range(1) == 0) ? 4'd7 : 4'd8;
                a.crm = 4'($urandom_range(15));
            end
        endcase
        return a;
    endfunction

    // Offer one word, hold it until the block takes it
    task automatic send_access(t_access a);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= a.req_type;
        i_op1           <= a.op1;
        i_op2           <= a.op2;
        i_primary_reg   <= a.crn;
        i_secondary_reg <= a.crm;
        i_write_value   <= a.wdata;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_access(a);
    endtask

    // Drop valid and wait out every read still owed
    task automatic drain_reads();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Switch the core variant once the pipeline is empty
    task automatic write_core_kind(bit kind);
        drain_reads();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= kind;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_core(kind);
        core_switches++;
    endtask

    // Result side: check accepted words, stall at random or for a long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) sb.check_read(o_read_value);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb_system_control_coprocessor_regs: errors");
        $finish;
    end

    initial begin
        t_access dir[$];
        sb              = new();
        send_idle       = 28;
        recv_idle       = 64;
        hold_req        = 1'b0;
        hold_left       = 0;
        core_switches   = 0;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_req_type      <= REQ_READ;
        i_op1           <= '0;
        i_op2           <= '0;
        i_primary_reg   <= '0;
        i_secondary_reg <= '0;
        i_write_value   <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_core_kind(1'b0);

        // Directed: reset values, ID space edges, writes to most writable registers,
        // many with all ones, maintenance and read-only writes, unmapped corners
        dir.push_back(mk(REQ_READ,  OP1_STD, OP2_0, CRN_ID, CRM_ZERO, '1));
        dir.push_back(mk(REQ_READ,  OP1_STD, 3'd3,  CRN_ID, CRM_ZERO, '0));
        dir.push_back(mk(REQ_READ,  OP1_STD, OP2_4, CRN_ID, CRM_ZERO, '0));
        dir.push_back(mk(REQ_READ,  OP1_STD, 3'd7,  CRN_ID, CRM_FEAT, '0));
        dir.push_back(mk(REQ_READ,  OP1_STD, OP2_0, CRN_CTRL, CRM_ZERO, '0));
        dir.push_back(mk(REQ_READ,  OP1_STD, OP2_1, CRN_CTRL, CRM_ZERO, '0));
        dir.push_back(mk(REQ_READ,  OP1_L2,  OP2_2, CRN_L2, CRM_ZERO, '0));
        dir.push_back(mk(REQ_WRITE, OP1_STD, OP2_0, CRN_CTRL, CRM_ZERO, '1));
        dir.push_back(mk(REQ_WRITE, OP1_STD, OP2_1, CRN_CTRL, CRM_ZERO, '1));
        dir.push_back(mk(REQ_WRITE, OP1_STD, OP2_2, CRN_CTRL, CRM_ZERO, '1));
        dir.push_back(mk(REQ_WRITE, OP1_STD, OP2_0, CRN_TTB, CRM_ZERO, '1));
        dir.push_back(mk(REQ_WRITE, OP1_STD, OP2_2, CRN_TTB, CRM_ZERO, 32'h5a5a_a5a5));
        dir.push_back(mk(REQ_WRITE, OP1_STD, OP2_0, CRN_DAC, CRM_ZERO, 32'h8000_0001));
        dir.push_back(mk(REQ_WRITE, OP1_L2,  OP2_2, CRN_L2, CRM_ZERO, '1));
        dir.push_back(mk(REQ_WRITE, OP1_STD, OP2_4, CRN_REMAP, CRM_REMAP, '1));
        dir.push_back(mk(REQ_WRITE, OP1_STD, OP2_0, 4'd7, 4'd5, '1));
        dir.push_back(mk(REQ_WRITE, OP1_STD, OP2_1, 4'd8, 4'd7, '1));
        dir.push_back(mk(REQ_WRITE, OP1_STD, OP2_0, CRN_ID, CRM_ZERO, '1));
        dir.push_back(mk(REQ_READ,  OP1_STD, OP2_0, CRN_CTRL, CRM_ZERO, '0));
        dir.push_back(mk(REQ_READ,  OP1_STD, OP2_1, CRN_CTRL, CRM_ZERO, '0));
        dir.push_back(mk(REQ_READ,  OP1_STD, OP2_2, CRN_CTRL, CRM_ZERO, '0));
        dir.push_back(mk(REQ_READ,  OP1_STD, OP2_2, CRN_TTB, CRM_ZERO, '0));
        dir.push_back(mk(REQ_READ,  OP1_L2,  OP2_2, CRN_L2, CRM_ZERO, '0));
        dir.push_back(mk(REQ_READ,  OP1_STD, OP2_4, CRN_REMAP, CRM_REMAP, '0));
        dir.push_back(mk(REQ_READ,  3'd7,    3'd7,  4'd15, 4'd15, '1));
        foreach (dir[i]) send_access(dir[i]);

        // Random phases: alternate variants, walk through the idling modes
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph / 2)
                0:       begin send_idle = 28; recv_idle = 64; end
                1:       begin send_idle = 64; recv_idle = 28; end
                default: begin send_idle = 0;  recv_idle = 0;  end
            endcase
            write_core_kind(ph % 2 == 0);
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (ph == 4 && n == 0) hold_req = 1'b1;
                if (ph == 2 && n == RAND_PER_PHASE / 2) drain_reads();
                send_access(random_access());
            end
        end

        // Wind down and report
        drain_reads();
        repeat (DRAIN_CYCLES * 2) @(posedge i_clk);
        $display("Covered %0d writes and %0d checked reads over %0d core variant writes,",
                 sb.writes_noted, sb.reads_checked, core_switches);
        $display("with random stalls on both sides and one long result hold-off.");
        if (sb.mismatches == 0) begin
            $display("tb_system_control_coprocessor_regs: clean");
        end else begin
            $display("tb_system_control_coprocessor_regs: errors");
        end
        $finish;
    end

endmodule
